>>> sv/sbos_pkg.sv
// ----------------------------------------------------------------------------
// sbos_pkg
// Shared types and constants of the sub-bass octave synthesizer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbos_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned CFG_W       = 24;
  localparam int unsigned CFG_IDX_W   = 3;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 3'd0,
    CFG_COEFF   = 3'd1,
    CFG_THRESH  = 3'd2,
    CFG_RELEASE = 3'd3,
    CFG_STEP    = 3'd4,
    CFG_WET     = 3'd5,
    CFG_DRY     = 3'd6
  } cfg_idx_e;

  // sub signal select
  localparam logic [1:0] MODE_TERN = 2'd0;
  localparam logic [1:0] MODE_OCT  = 2'd1;
  localparam logic [1:0] MODE_DUAL = 2'd2;
  localparam logic [1:0] MODE_SINE = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_t;

endpackage

`default_nettype wire

>>> sv/sub_bass_octave_synth.sv
// Sub-bass octave synthesizer: one stereo sample in, one stereo sample out.
// All products run through a single shift-and-add multiply-accumulate unit
// that consumes one coefficient bit per cycle; each product is a load, one
// step per coefficient bit and a write-back. A sample in modes 0 to 2 takes
// 8 products plus the classifier and output steps; mode 3 adds the envelope
// decay, the table index and the sine scaling products plus a ROM read, and
// skips the envelope decay when the envelope retriggers. A finished sample
// waits in the output register while the next one is taken in. The sine
// table is a ROM built at elaboration. Register writes are taken only while
// no sample is in flight.
// ----------------------------------------------------------------------------
// sub_bass_octave_synth
// Low-passed L+R drives a ternary classifier, an octave divider or an enveloped sine; the filtered
// sub signal is mixed back with the dry input per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sub_bass_octave_synth #(
  parameter int unsigned PHASE_BITS = 24,
  parameter int unsigned SINE_DEPTH = 1024
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  sbos_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output sbos_pkg::out_t                 out_data_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [sbos_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [sbos_pkg::CFG_W-1:0]      cfg_data_i
);

  import sbos_pkg::*;

  localparam int unsigned ACC_W  = 60;
  localparam int unsigned ST_W   = 32;
  localparam int unsigned SINE_W = 24;
  localparam int unsigned FRAC_C = 24;
  localparam int unsigned IDX_W  = $clog2(SINE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(CFG_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CFG_W - 1);

  localparam logic [CFG_W-1:0] MODE3_COEFF = 24'd301990;
  localparam logic [CFG_W-1:0] ENV_FULL    = 24'hFFFFFF;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned SINE_AMP    = 64'd8388607;

  localparam logic signed [ACC_W-1:0] Rnd24 = {{(ACC_W-24){1'b0}}, 1'b1, 23'b0};
  localparam logic signed [ACC_W-1:0] Rnd23 = {{(ACC_W-23){1'b0}}, 1'b1, 22'b0};
  localparam logic signed [ACC_W-1:0] Max32 = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] Min32 = ~Max32;
  localparam logic signed [ACC_W-1:0] MaxSmp =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MinSmp = ~MaxSmp;
  localparam logic signed [ST_W-1:0]  OneQ23 = 32'sh0080_0000;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LPA  = 4'd1;
  localparam logic [3:0] ST_LPB  = 4'd2;
  localparam logic [3:0] ST_CLS  = 4'd3;
  localparam logic [3:0] ST_ENV  = 4'd4;
  localparam logic [3:0] ST_IDX  = 4'd5;
  localparam logic [3:0] ST_ROM  = 4'd6;
  localparam logic [3:0] ST_SIN  = 4'd7;
  localparam logic [3:0] ST_OPA  = 4'd8;
  localparam logic [3:0] ST_OPB  = 4'd9;
  localparam logic [3:0] ST_MXL  = 4'd10;
  localparam logic [3:0] ST_MXL2 = 4'd11;
  localparam logic [3:0] ST_MXR  = 4'd12;
  localparam logic [3:0] ST_MXR2 = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  // multiply phases
  localparam logic [1:0] PH_LOAD = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  function automatic longint unsigned sin_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic logic signed [ST_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > Max32) begin
      return Max32[ST_W-1:0];
    end else if (v < Min32) begin
      return Min32[ST_W-1:0];
    end
    return v[ST_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
    input logic signed [ACC_W-1:0] v
  );
    if (v > MaxSmp) begin
      return MaxSmp[SAMPLE_BITS-1:0];
    end else if (v < MinSmp) begin
      return MinSmp[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  // sine ROM, entries fixed at elaboration
  logic signed [SINE_W-1:0] sine_rom [SINE_DEPTH];

  for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_sine
    localparam longint unsigned N    = 4 * g;
    localparam longint unsigned Quad = N / SINE_DEPTH;
    localparam longint unsigned Rem  = N % SINE_DEPTH;
    localparam longint unsigned R    = (Quad % 2 == 1) ? SINE_DEPTH - Rem : Rem;
    localparam longint unsigned S    = sin_q30((PI_HALF_Q30 * R) / SINE_DEPTH);
    localparam longint unsigned V    = (S * SINE_AMP + (64'd1 << 29)) >> 30;
    localparam logic signed [SINE_W-1:0] Mag = SINE_W'(V);
    assign sine_rom[g] = (Quad >= 2) ? -Mag : Mag;
  end

  // control and filter state
  logic [3:0]              state_q, state_d;
  logic [1:0]              ph_q, ph_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              mode_q, mode_d;
  logic [CFG_W-1:0]        coeff_q, coeff_d, thr_q, thr_d, rel_q, rel_d;
  logic [CFG_W-1:0]        step_q, step_d, wet_q, wet_d, dry_q, dry_d;
  logic signed [ST_W-1:0]  lpa_q, lpa_d, lpb_q, lpb_d, opa_q, opa_d, opb_q, opb_d;
  logic [CFG_W-1:0]        env_q, env_d;
  logic [PHASE_BITS-1:0]   phase_q, phase_d;
  logic                    div_q, div_d, oct_q, oct_d;

  // datapath
  logic signed [ACC_W-1:0] acc_q, acc_d, mc_q, mc_d;
  logic [CFG_W-1:0]        mp_q, mp_d;
  logic signed [SAMPLE_BITS-1:0] a_q, a_d, b_q, b_d;
  logic signed [ST_W-1:0]  sub_q, sub_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic signed [SINE_W-1:0] rom_q;
  out_t                    res_q, res_d, out_q, out_d;

  // operand selection for the multiply load
  logic [CFG_W-1:0]        fi;
  logic signed [ACC_W-1:0] mc_ld, acc_ld;
  logic [CFG_W-1:0]        mp_ld;
  logic                    keep_acc;

  assign fi          = (mode_q == MODE_SINE) ? MODE3_COEFF : coeff_q;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    mc_ld    = '0;
    mp_ld    = fi;
    acc_ld   = '0;
    keep_acc = 1'b0;
    case (state_q)
      // one pole as y*2^24 + fi*(x - y), rounding bias preloaded
      ST_LPA: begin
        mc_ld  = ACC_W'(a_q) + ACC_W'(b_q) - ACC_W'(lpa_q);
        acc_ld = (ACC_W'(lpa_q) <<< FRAC_C) + Rnd24;
      end
      ST_LPB: begin
        mc_ld  = ACC_W'(lpa_q) - ACC_W'(lpb_q);
        acc_ld = (ACC_W'(lpb_q) <<< FRAC_C) + Rnd24;
      end
      ST_ENV: begin
        mc_ld = ACC_W'(env_q);
        mp_ld = rel_q;
      end
      ST_IDX: begin
        mc_ld = ACC_W'(phase_q);
        mp_ld = CFG_W'(SINE_DEPTH);
      end
      ST_SIN: begin
        mc_ld  = ACC_W'(rom_q);
        mp_ld  = env_q;
        acc_ld = Rnd24;
      end
      ST_OPA: begin
        mc_ld  = ACC_W'(sub_q) - ACC_W'(opa_q);
        acc_ld = (ACC_W'(opa_q) <<< FRAC_C) + Rnd24;
      end
      ST_OPB: begin
        mc_ld  = ACC_W'(opa_q) - ACC_W'(opb_q);
        acc_ld = (ACC_W'(opb_q) <<< FRAC_C) + Rnd24;
      end
      ST_MXL: begin
        mc_ld  = ACC_W'(a_q);
        mp_ld  = dry_q;
        acc_ld = Rnd23;
      end
      ST_MXR: begin
        mc_ld  = ACC_W'(b_q);
        mp_ld  = dry_q;
        acc_ld = Rnd23;
      end
      ST_MXL2, ST_MXR2: begin
        mc_ld    = ACC_W'(opb_q);
        mp_ld    = wet_q;
        keep_acc = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // ternary classifier on the second input stage
  logic signed [ST_W+1:0] f2x, thx, negf2, dbl;
  logic                   gt, lt, div_n, oct_n;
  logic signed [ST_W-1:0] tern;

  always_comb begin
    f2x   = (ST_W+2)'(lpb_q);
    thx   = (ST_W+2)'(thr_q);
    gt    = f2x > thx;
    lt    = f2x < -thx;
    div_n = (gt || lt) ? lt : div_q;
    oct_n = oct_q ^ (lt && !div_q);
    tern  = gt ? OneQ23 : (lt ? -OneQ23 : '0);
    negf2 = oct_n ? -f2x : f2x;
    dbl   = negf2 <<< 1;
  end

  logic cfg_hit;

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    mode_d      = mode_q;
    coeff_d     = coeff_q;
    thr_d       = thr_q;
    rel_d       = rel_q;
    step_d      = step_q;
    wet_d       = wet_q;
    dry_d       = dry_q;
    lpa_d       = lpa_q;
    lpb_d       = lpb_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    env_d       = env_q;
    phase_d     = phase_q;
    div_d       = div_q;
    oct_d       = oct_q;
    acc_d       = acc_q;
    mc_d        = mc_q;
    mp_d        = mp_q;
    a_d         = a_q;
    b_d         = b_q;
    sub_d       = sub_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_d       = out_q;
    cfg_hit     = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      cfg_hit = 1'b1;
      case (cfg_index_i)
        CFG_MODE:    mode_d  = cfg_data_i[1:0];
        CFG_COEFF:   coeff_d = cfg_data_i;
        CFG_THRESH:  thr_d   = cfg_data_i;
        CFG_RELEASE: rel_d   = cfg_data_i;
        CFG_STEP:    step_d  = cfg_data_i;
        CFG_WET:     wet_d   = cfg_data_i;
        CFG_DRY:     dry_d   = cfg_data_i;
        default:     cfg_hit = 1'b0;
      endcase
      if (cfg_hit) begin
        div_d = 1'b0;
        oct_d = 1'b0;
      end
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          a_d     = in_data_i.left_in;
          b_d     = in_data_i.right_in;
          ph_d    = PH_LOAD;
          state_d = ST_LPA;
        end
      end
      ST_CLS: begin
        div_d = div_n;
        oct_d = oct_n;
        case (mode_q)
          MODE_TERN: begin
            sub_d   = tern;
            state_d = ST_OPA;
          end
          MODE_OCT: begin
            sub_d   = oct_n ? -tern : tern;
            state_d = ST_OPA;
          end
          MODE_DUAL: begin
            sub_d   = sat32(ACC_W'(dbl));
            state_d = ST_OPA;
          end
          default: begin
            if (gt) begin
              env_d   = ENV_FULL;
              state_d = ST_IDX;
            end else begin
              state_d = ST_ENV;
            end
          end
        endcase
      end
      ST_ROM: begin
        state_d = ST_SIN;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        case (ph_q)
          PH_LOAD: begin
            acc_d = keep_acc ? acc_q : acc_ld;
            mc_d  = mc_ld;
            mp_d  = mp_ld;
            cnt_d = '0;
            ph_d  = PH_RUN;
          end
          PH_RUN: begin
            if (mp_q[0]) begin
              acc_d = acc_q + mc_q;
            end
            mc_d  = mc_q <<< 1;
            mp_d  = mp_q >> 1;
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == CNT_LAST) begin
              ph_d = PH_DONE;
            end
          end
          default: begin
            ph_d = PH_LOAD;
            case (state_q)
              ST_LPA: begin
                lpa_d   = sat32(acc_q >>> FRAC_C);
                state_d = ST_LPB;
              end
              ST_LPB: begin
                lpb_d   = sat32(acc_q >>> FRAC_C);
                state_d = ST_CLS;
              end
              ST_ENV: begin
                env_d   = acc_q[FRAC_C +: CFG_W];
                state_d = ST_IDX;
              end
              ST_IDX: begin
                idx_d   = acc_q[PHASE_BITS +: IDX_W];
                state_d = ST_ROM;
              end
              ST_SIN: begin
                sub_d   = ST_W'(acc_q >>> FRAC_C);
                phase_d = phase_q + PHASE_BITS'(step_q);
                state_d = ST_OPA;
              end
              ST_OPA: begin
                opa_d   = sat32(acc_q >>> FRAC_C);
                state_d = ST_OPB;
              end
              ST_OPB: begin
                opb_d   = sat32(acc_q >>> FRAC_C);
                state_d = ST_MXL;
              end
              ST_MXL:  state_d = ST_MXL2;
              ST_MXL2: begin
                res_d.left_out = sat_smp(acc_q >>> (FRAC_C - 1));
                state_d        = ST_MXR;
              end
              ST_MXR:  state_d = ST_MXR2;
              ST_MXR2: begin
                res_d.right_out = sat_smp(acc_q >>> (FRAC_C - 1));
                state_d         = ST_OUT;
              end
              default: state_d = ST_IDLE;
            endcase
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_LOAD;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_TERN;
      coeff_q     <= 24'd265904;
      thr_q       <= 24'd529280;
      rel_q       <= 24'd16775334;
      step_q      <= 24'd30595;
      wet_q       <= 24'd2516582;
      dry_q       <= 24'd8388608;
      lpa_q       <= '0;
      lpb_q       <= '0;
      opa_q       <= '0;
      opb_q       <= '0;
      env_q       <= '0;
      phase_q     <= '0;
      div_q       <= 1'b0;
      oct_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
      coeff_q     <= coeff_d;
      thr_q       <= thr_d;
      rel_q       <= rel_d;
      step_q      <= step_d;
      wet_q       <= wet_d;
      dry_q       <= dry_d;
      lpa_q       <= lpa_d;
      lpb_q       <= lpb_d;
      opa_q       <= opa_d;
      opb_q       <= opb_d;
      env_q       <= env_d;
      phase_q     <= phase_d;
      div_q       <= div_d;
      oct_q       <= oct_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
    a_q   <= a_d;
    b_q   <= b_d;
    sub_q <= sub_d;
    idx_q <= idx_d;
    res_q <= res_d;
    out_q <= out_d;
    if (state_q == ST_ROM) begin
      rom_q <= sine_rom[idx_q];
    end
  end

endmodule

`default_nettype wire

>>> sv/sbos_checker.sv
// ----------------------------------------------------------------------------
// sbos_checker
// Port-level checks for the sub-bass octave synthesizer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sbos_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_valid_i,
  input wire            in_ready_i,
  input wire            out_valid_i,
  input wire            out_ready_i,
  input sbos_pkg::out_t out_data_i,
  input wire            cfg_valid_i,
  input wire            cfg_ready_i
);

  logic       in_beat, out_beat;
  logic [1:0] pend_q, pend_d;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // samples taken but not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_beat && !out_beat) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_beat && out_beat) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output beat dropped or changed while stalled");

  a_out_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("output beat without a sample in flight");

  a_in_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> pend_q <= 2'd1)
    else $error("sample taken with two already in flight");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ready_i)
    else $error("second sample taken while the first is in work");

  a_cfg_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> cfg_ready_i || !cfg_valid_i)
    else $error("sample port open while register port is closed");

endmodule

bind sub_bass_octave_synth sbos_checker u_sbos_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_i (cfg_ready_o)
);

`default_nettype wire

>>> sim/sbos_mix_check.sv
// ----------------------------------------------------------------------------
// sbos_mix_check
// Watches the sample, result and register channels of the sub-bass octave
// synthesizer. Each input beat is run through a bit-exact model of the
// filters, divider, oscillator and mixer. Each output beat is compared
// against the oldest predicted stereo sample.
// ----------------------------------------------------------------------------
module sbos_mix_check
  import sbos_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 24,
  parameter int unsigned SINE_DEPTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_t                 out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   pending_o,
  output int                   errors_o
);

  localparam longint COEFF_ONE  = 64'sd16777216;
  localparam longint SINE_COEFF = 64'sd301990;   // 0.018 in Q0.24, sine mode only

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned SINE_AMP    = 64'd8388607;

  // register copies
  logic [1:0]       mode_r;
  logic [CFG_W-1:0] coeff_r, thresh_r, release_r, step_r, wet_r, dry_r;

  // model state, filters in Q8.23
  longint                lp_in_a, lp_in_b, lp_out_a, lp_out_b;
  logic [23:0]           env_level;
  logic [PHASE_BITS-1:0] osc_phase;
  logic                  div_neg, oct_neg;
  int                    sine_rom [SINE_DEPTH];

  out_t mixed_q [$];
  int   error_cnt = 0;

  // sine table from a Taylor series on the first quadrant, mirrored
  initial begin
    longint unsigned n, quad, rem, x, x2, t, s, v;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      n    = 4 * k;
      quad = n / SINE_DEPTH;
      rem  = n % SINE_DEPTH;
      if (quad[0]) rem = SINE_DEPTH - rem;
      x  = (PI_HALF_Q30 * rem) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      v  = (s * SINE_AMP + (64'd1 << 29)) >> 30;
      sine_rom[k] = (quad >= 2) ? -int'(v) : int'(v);
    end
  end

  // round half up, then arithmetic shift
  function automatic longint rnd_shift(longint v, int unsigned sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp(longint v, int unsigned bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint one_pole(longint y, longint x, longint fi);
    return clamp(rnd_shift((COEFF_ONE - fi) * y + fi * x, 24), 32);
  endfunction

  function automatic out_t mix_sample(in_t smp);
    longint a, b, fi, th, f2, sub, wetv, l, r, idx;
    int     tern;
    out_t   res;
    a  = longint'($signed(smp.left_in));
    b  = longint'($signed(smp.right_in));
    fi = (mode_r == MODE_SINE) ? SINE_COEFF : longint'(coeff_r);
    th = longint'(thresh_r);

    lp_in_a = one_pole(lp_in_a, a + b, fi);
    lp_in_b = one_pole(lp_in_b, lp_in_a, fi);
    f2 = lp_in_b;

    if (f2 > th) tern = 1;
    else if (f2 < -th) tern = -1;
    else tern = 0;
    // divider follows the nonzero sign; octave flips on each turn negative
    if (tern != 0 && ((tern < 0) != div_neg)) begin
      div_neg = ~div_neg;
      if (div_neg) oct_neg = ~oct_neg;
    end

    sub = tern * 64'sd8388608;
    case (mode_r)
      MODE_OCT: begin
        if (oct_neg) sub = -sub;
      end
      MODE_DUAL: begin
        sub = clamp(2 * (oct_neg ? -f2 : f2), 32);
      end
      MODE_SINE: begin
        if (f2 > th) env_level = 24'hFFFFFF;
        else env_level = 24'((longint'(env_level) * longint'(release_r)) >>> 24);
        idx = (longint'(osc_phase) * SINE_DEPTH) >>> PHASE_BITS;
        sub = rnd_shift(longint'(env_level) * longint'(sine_rom[idx]), 24);
        osc_phase = osc_phase + PHASE_BITS'(step_r);
      end
      default: ;
    endcase

    lp_out_a = one_pole(lp_out_a, sub, fi);
    lp_out_b = one_pole(lp_out_b, lp_out_a, fi);

    wetv = lp_out_b * longint'(wet_r);
    l = clamp(rnd_shift(a * longint'(dry_r) + wetv, 23), SAMPLE_BITS);
    r = clamp(rnd_shift(b * longint'(dry_r) + wetv, 23), SAMPLE_BITS);
    res.left_out  = l[SAMPLE_BITS-1:0];
    res.right_out = r[SAMPLE_BITS-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_cnt++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_r    = MODE_TERN;
      coeff_r   = 24'd265904;
      thresh_r  = 24'd529280;
      release_r = 24'd16775334;
      step_r    = 24'd30595;
      wet_r     = 24'd2516582;
      dry_r     = 24'd8388608;
      lp_in_a   = 0;
      lp_in_b   = 0;
      lp_out_a  = 0;
      lp_out_b  = 0;
      env_level = '0;
      osc_phase = '0;
      div_neg   = 1'b0;
      oct_neg   = 1'b0;
      mixed_q.delete();
      pending_o <= 0;
      errors_o  <= error_cnt;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (mixed_q.size() == 0) begin
          report_mismatch("output beat with nothing pending, left",
                          longint'($signed(out_data_i.left_out)), 0);
        end else begin
          out_t want;
          want = mixed_q.pop_front();
          if (out_data_i.left_out !== want.left_out)
            report_mismatch("left_out", longint'($signed(out_data_i.left_out)),
                            longint'($signed(want.left_out)));
          if (out_data_i.right_out !== want.right_out)
            report_mismatch("right_out", longint'($signed(out_data_i.right_out)),
                            longint'($signed(want.right_out)));
        end
      end
      if (in_valid_i && in_ready_i)
        mixed_q.push_back(mix_sample(in_data_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MODE:    mode_r    = cfg_data_i[1:0];
          CFG_COEFF:   coeff_r   = cfg_data_i;
          CFG_THRESH:  thresh_r  = cfg_data_i;
          CFG_RELEASE: release_r = cfg_data_i;
          CFG_STEP:    step_r    = cfg_data_i;
          CFG_WET:     wet_r     = cfg_data_i;
          CFG_DRY:     dry_r     = cfg_data_i;
          default: ;
        endcase
        // a write to a real register re-arms both flip-flops
        if (cfg_index_i <= CFG_DRY) begin
          div_neg = 1'b0;
          oct_neg = 1'b0;
        end
      end
      pending_o <= mixed_q.size();
      errors_o  <= error_cnt;
    end
  end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the sub-bass octave synthesizer: a directed pass over extreme
// samples and settings in every mode, then random phases of square-like
// program material with random register settings, bursty idling on both
// sides and one long output hold-off. Checking is done in sbos_mix_check.
// ----------------------------------------------------------------------------
module tb_top;
  import sbos_pkg::*;

  localparam int unsigned PHASE_BITS = 24;
  localparam int unsigned SINE_DEPTH = 1024;

  localparam logic [CFG_IDX_W-1:0]   CFG_NONE = 3'd7;  // unmapped index
  localparam logic [SAMPLE_BITS-1:0] S_MAX    = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0] S_MIN    = 24'h800000;
  localparam logic [SAMPLE_BITS-1:0] S_ZERO   = 24'h000000;

  localparam int RAND_PHASES    = 10;
  localparam int PHASE_LEN      = 38;
  localparam int SQUEEZE_PHASE  = 3;
  localparam int SQUEEZE_CYCLES = 1500;
  localparam int STALL_LIMIT    = 6000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 300;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_t                  in_data   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_ready, out_valid, cfg_ready;
  out_t                 out_data;
  int                   pending, errors;

  bit sender_gaps  = 1'b1;
  bit rx_stalls    = 1'b1;
  bit squeeze_req  = 1'b0;
  bit squeeze_done = 1'b0;

  sub_bass_octave_synth #(
    .PHASE_BITS (PHASE_BITS),
    .SINE_DEPTH (SINE_DEPTH)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  sbos_mix_check #(
    .PHASE_BITS (PHASE_BITS),
    .SINE_DEPTH (SINE_DEPTH)
  ) u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic offer_sample(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{left_in: l, right_in: r};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // pending is a registered output of the checker
  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 24'h000000;
      1:       return 24'h800000;
      2:       return 24'hFFFFFF;
      default: return 24'($urandom_range(0, 24'h800000));
    endcase
  endfunction

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_ready <= 1'b0;
        n = 0;
        while (n < SQUEEZE_CYCLES) begin
          @(posedge clk);
          n++;
        end
        squeeze_done = 1'b1;
      end else if (rx_stalls && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  end

  // watchdog: cycles without any beat on any channel
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int period, amp, lvl;
    logic [SAMPLE_BITS-1:0] l, r;
    logic [CFG_W-1:0] val;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, ternary square, full-scale corners
    offer_sample(S_MAX, S_MAX);
    offer_sample(S_MIN, S_MIN);
    offer_sample(S_ZERO, S_ZERO);
    offer_sample(S_MAX, S_MIN);
    offer_sample(S_MIN, S_MAX);
    in_valid <= 1'b0;
    wait_idle();

    // octave divider, near pass-through filter, zero threshold:
    // flips every sample; mode data carries junk above bit 1
    write_reg(CFG_MODE, {22'h3FFFFF, MODE_OCT});
    write_reg(CFG_COEFF, 24'hFFFFFF);
    write_reg(CFG_THRESH, 24'h000000);
    write_reg(CFG_NONE, 24'h5A5A5A);
    cfg_valid <= 1'b0;
    for (int k = 0; k < 6; k++)
      offer_sample(k[0] ? S_MIN : S_MAX, k[0] ? S_MIN : S_MAX);
    offer_sample(S_ZERO, S_ZERO);
    in_valid <= 1'b0;
    wait_idle();

    // divided dual, frozen filters, oversized threshold and gains: saturation
    write_reg(CFG_MODE, {22'h0, MODE_DUAL});
    write_reg(CFG_COEFF, 24'h000000);
    write_reg(CFG_THRESH, 24'hFFFFFF);
    write_reg(CFG_WET, 24'hFFFFFF);
    write_reg(CFG_DRY, 24'hFFFFFF);
    cfg_valid <= 1'b0;
    offer_sample(S_MAX, S_MIN);
    offer_sample(S_MIN, S_MAX);
    offer_sample(S_MAX, S_MAX);
    in_valid <= 1'b0;
    wait_idle();

    // sine mode ignores the coefficient; retrigger, then instant release
    write_reg(CFG_MODE, {22'h0, MODE_SINE});
    write_reg(CFG_COEFF, 24'h000001);
    write_reg(CFG_THRESH, 24'h000000);
    write_reg(CFG_RELEASE, 24'h000000);
    write_reg(CFG_STEP, 24'h400000);
    write_reg(CFG_WET, 24'h800000);
    write_reg(CFG_DRY, 24'h000000);
    cfg_valid <= 1'b0;
    for (int k = 0; k < 6; k++)
      offer_sample(k < 3 ? S_MAX : S_MIN, k < 3 ? S_MAX : S_MIN);
    in_valid <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      sender_gaps = (ph != RAND_PHASES - 1) && (ph != SQUEEZE_PHASE);
      rx_stalls   = (ph != RAND_PHASES - 1);

      write_reg(CFG_MODE, {22'($urandom), 2'($urandom)});
      if ($urandom_range(0, 2) == 0) write_reg(CFG_NONE, 24'($urandom));
      case ($urandom_range(0, 7))
        0:       val = 24'h000000;
        1:       val = 24'hFFFFFF;
        2, 3:    val = 24'($urandom);
        default: val = 24'($urandom_range(24'h100000, 24'hFFFFFF));
      endcase
      write_reg(CFG_COEFF, val);
      case ($urandom_range(0, 7))
        0:       val = 24'h000000;
        1:       val = 24'h800000;
        2:       val = 24'hFFFFFF;
        default: val = 24'($urandom_range(0, 24'h400000));
      endcase
      write_reg(CFG_THRESH, val);
      case ($urandom_range(0, 5))
        0:       val = 24'h000000;
        1:       val = 24'hFFFFFF;
        2:       val = 24'($urandom);
        default: val = 24'($urandom_range(24'hE00000, 24'hFFFFFF));
      endcase
      write_reg(CFG_RELEASE, val);
      case ($urandom_range(0, 5))
        0:       val = 24'h000000;
        1:       val = 24'h800000;
        default: val = 24'($urandom_range(0, 24'h800000));
      endcase
      write_reg(CFG_STEP, val);
      write_reg(CFG_WET, pick_gain());
      write_reg(CFG_DRY, pick_gain());
      cfg_valid <= 1'b0;

      if (ph == SQUEEZE_PHASE) squeeze_req = 1'b1;

      // square-like material with noise, plus some raw random samples
      period = $urandom_range(2, 30);
      amp    = $urandom_range(0, 8323071);
      for (int k = 0; k < PHASE_LEN; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          l = 24'($urandom);
          r = 24'($urandom);
        end else begin
          lvl = ((k / period) % 2) ? -amp : amp;
          l = 24'(lvl + int'($urandom_range(0, 131072)) - 65536);
          r = 24'(lvl + int'($urandom_range(0, 131072)) - 65536);
        end
        offer_sample(l, r);
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
